>>> rtl/crtm_pkg.sv
// Shared types, constants and a helper function for the cron rule table matcher.
package crtm_pkg;

   localparam int MAX_RULES = 16;
   localparam int CNT_W     = $clog2(MAX_RULES + 1);
   localparam int MASK_W    = 16;
   localparam int SLOT_W    = 4;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_ILLEGAL = 2'd1;
   localparam status_type STATUS_FULL    = 2'd2;

   // two's complement fields, all ones is the wildcard
   typedef struct packed {
      logic [3:0] week_day;
      logic [4:0] month;
      logic [5:0] month_day;
      logic [5:0] hour;
      logic [6:0] minute;
   } rule_type;

   // month is already counted from one
   typedef struct packed {
      logic [2:0] week_day;
      logic [4:0] month;
      logic [4:0] month_day;
      logic [4:0] hour;
      logic [5:0] minute;
   } now_type;

   typedef struct packed {
      now_type           now;
      logic [CNT_W-1:0]  left;
      logic [MASK_W-1:0] pos;
      logic [MASK_W-1:0] mask;
   } token_type;

   function automatic logic rule_legal(input rule_type r);
      logic ok_min, ok_hour, ok_mday, ok_mon, ok_wday;
      ok_min  = (r.minute == '1) || (!r.minute[6] && r.minute <= 7'd59);
      ok_hour = (r.hour == '1) || (!r.hour[5] && r.hour <= 6'd23);
      ok_mday = (r.month_day == '1) || (!r.month_day[5] && r.month_day != 6'd0);
      ok_mon  = (r.month == '1) ||
                (!r.month[4] && r.month != 5'd0 && r.month <= 5'd12);
      ok_wday = (r.week_day == '1) || (!r.week_day[3] && r.week_day <= 4'd6);
      return ok_min && ok_hour && ok_mday && ok_mon && ok_wday;
   endfunction

endpackage

>>> rtl/crtm_cell.sv
// One rule slot: stores a rule and checks the passing tick token against it.
module crtm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  crtm_pkg::rule_type   wr_rule,
   input  logic                 tok_valid,
   input  crtm_pkg::token_type  tok_in,
   output logic                 tok_valid_out,
   output crtm_pkg::token_type  tok_out
);

   crtm_pkg::rule_type  rule_ff;
   logic                valid_ff;
   crtm_pkg::token_type tok_ff, tok_in_next;
   logic                active, hit;
   logic                m_min, m_hour, m_mday, m_mon, m_wday;

   assign active = (tok_in.left != '0);
   assign m_min  = (rule_ff.minute == '1) || (rule_ff.minute == {1'b0, tok_in.now.minute});
   assign m_hour = (rule_ff.hour == '1) || (rule_ff.hour == {1'b0, tok_in.now.hour});
   assign m_mday = (rule_ff.month_day == '1) ||
                   (rule_ff.month_day == {1'b0, tok_in.now.month_day});
   assign m_mon  = (rule_ff.month == '1) || (rule_ff.month == tok_in.now.month);
   assign m_wday = (rule_ff.week_day == '1) ||
                   (rule_ff.week_day == {1'b0, tok_in.now.week_day});
   assign hit    = active && m_min && m_hour && m_mday && m_mon && m_wday;

   always_comb begin
      tok_in_next      = tok_in;
      tok_in_next.left = active ? tok_in.left - crtm_pkg::CNT_W'(1) : tok_in.left;
      tok_in_next.pos  = tok_in.pos << 1;
      tok_in_next.mask = hit ? (tok_in.mask | tok_in.pos) : tok_in.mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_valid;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_next;
      if (wr_en) begin
         rule_ff <= wr_rule;
      end
   end

   assign tok_valid_out = valid_ff;
   assign tok_out       = tok_ff;

endmodule

>>> rtl/cron_rule_table_matcher_top.sv
// Top level: request decode, rule count, chain of rule cells and response register.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata (rule, time), req_tuser (command)
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata (status, slot, due mask)
//
// An add is held, then loaded into the output register; a tick first passes every cell
// of the chain, one register per cell. One request is in flight at a time; a response
// may wait in the output register while the next request is accepted. Reset clears the
// rule count and all control state; stored rules are unknown until written. A stalled
// response holds the block in its done state until the output register frees up.
module cron_rule_table_matcher_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rule_minute, rule_hour, rule_month_day, rule_month, rule_week_day,
   // now_minute, now_hour, now_month_day, now_month_zero, now_week_day
   input  logic [crtm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status, slot_index, due_mask
   output logic [crtm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int N = crtm_pkg::MAX_RULES;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [crtm_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   crtm_pkg::status_type       status_hold_ff, status_hold_in;
   logic [crtm_pkg::SLOT_W-1:0] slot_hold_ff, slot_hold_in;
   logic [crtm_pkg::MASK_W-1:0] mask_hold_ff, mask_hold_in;
   logic [crtm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   crtm_pkg::rule_type  rule;
   crtm_pkg::now_type   now;
   crtm_pkg::token_type launch;
   crtm_pkg::token_type tok [0:N];
   logic [N:0]          tok_valid;
   logic [N-1:0]        wr_en;

   logic req_ok, add_ok, tick_ok, legal, full, write, load;

   assign rule.minute    = req_tdata[6:0];
   assign rule.hour      = req_tdata[12:7];
   assign rule.month_day = req_tdata[18:13];
   assign rule.month     = req_tdata[23:19];
   assign rule.week_day  = req_tdata[27:24];
   assign now.minute     = req_tdata[33:28];
   assign now.hour       = req_tdata[38:34];
   assign now.month_day  = req_tdata[43:39];
   assign now.month      = {1'b0, req_tdata[47:44]} + 5'd1;
   assign now.week_day   = req_tdata[50:48];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_ok     = req_tvalid && req_tready;
   assign add_ok     = req_ok && (req_tuser == crtm_pkg::CMD_ADD);
   assign tick_ok    = req_ok && (req_tuser == crtm_pkg::CMD_TICK);
   assign legal      = crtm_pkg::rule_legal(rule);
   assign full       = (count_ff == crtm_pkg::CNT_W'(N));
   assign write      = add_ok && legal && !full;
   assign load       = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      launch      = '0;
      launch.now  = now;
      launch.left = count_ff;
      launch.pos  = crtm_pkg::MASK_W'(1);
   end

   assign tok[0]       = launch;
   assign tok_valid[0] = tick_ok;

   for (genvar k = 0; k < N; k++) begin : g_cell
      assign wr_en[k] = write && (count_ff == crtm_pkg::CNT_W'(k));
      crtm_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .wr_en         (wr_en[k]),
         .wr_rule       (rule),
         .tok_valid     (tok_valid[k]),
         .tok_in        (tok[k]),
         .tok_valid_out (tok_valid[k+1]),
         .tok_out       (tok[k+1])
      );
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = write ? count_ff + crtm_pkg::CNT_W'(1) : count_ff;
      status_hold_in = status_hold_ff;
      slot_hold_in   = slot_hold_ff;
      mask_hold_in   = mask_hold_ff;
      rsp_valid_in   = load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      case (state_ff)
         ST_IDLE: begin
            if (add_ok) begin
               state_in     = ST_DONE;
               mask_hold_in = '0;
               if (!legal) begin
                  status_hold_in = crtm_pkg::STATUS_ILLEGAL;
                  slot_hold_in   = '0;
               end else if (full) begin
                  status_hold_in = crtm_pkg::STATUS_FULL;
                  slot_hold_in   = '0;
               end else begin
                  status_hold_in = crtm_pkg::STATUS_OK;
                  slot_hold_in   = crtm_pkg::SLOT_W'(count_ff);
               end
            end else if (tick_ok) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tok_valid[N]) begin
               state_in       = ST_DONE;
               status_hold_in = crtm_pkg::STATUS_OK;
               slot_hold_in   = '0;
               mask_hold_in   = tok[N].mask;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_hold_ff <= status_hold_in;
      slot_hold_ff   <= slot_hold_in;
      mask_hold_ff   <= mask_hold_in;
      if (load) begin
         rsp_data_ff <= {2'b00, mask_hold_ff, slot_hold_ff, status_hold_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/crtm_checker.sv
// Port-level checks for the cron rule table matcher, bound to the top level.
module crtm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [crtm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != crtm_pkg::STATUS_FULL + 2'd1)
      else $error("undefined status code");

   a_refusal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != crtm_pkg::STATUS_OK
         |-> rsp_tdata[5:2] == 4'd0 && rsp_tdata[21:6] == 16'd0)
      else $error("refused add carries slot or mask");

   a_mask_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21:6] != 16'd0 |-> rsp_tdata[5:2] == 4'd0)
      else $error("tick response carries a slot");

endmodule

bind cron_rule_table_matcher_top crtm_checker u_crtm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
